// ----- sv/rc4_pkg.sv -----
`default_nettype none

package rc4_pkg;

  localparam int MAX_KEY_BYTES = 256;

  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] value;
    logic       key_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       no_key;
  } out_item_t;

endpackage

`default_nettype wire

// ----- sv/rc4_stream_cipher_top.sv -----
// rc4 stream cipher
// in_item: command selects key load or data byte. key bytes are stored one per
// cycle while in_stall is low; the byte with key_last set starts the key
// schedule, which fills the permutation memory and scrambles it (read, read,
// write, write per entry); in_stall stays high until the schedule ends.
// key bytes give no result. a data byte gives one result on out_item: the
// input byte xor one keystream byte, or the byte unchanged with no_key set
// when no key has been scheduled since reset.
// a keyed data byte passes through the G1, G2 and G3 steps: its result is
// loaded into the output register in G3 and the next item is taken once the
// engine is back in idle. the steps follow the read, read, read-and-write, write
// sequence on the single write port of the permutation memory. pass-through
// bytes and key bytes are taken every cycle while the output register is free.
// the output register holds a result while out_stall is high; the engine
// waits in its final step and in_stall stays high until the register frees.
// reset (rst_n low at a clock edge) clears the key count, the indices and the
// key-ready flag; the memories are not cleared.
`default_nettype none

module rc4_stream_cipher_top
  import rc4_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire in_item_t  in_item,
  output logic           in_stall,
  output logic           out_valid,
  output out_item_t      out_item,
  input  wire logic      out_stall
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_INIT = 4'd1;
  localparam logic [3:0] ST_SA   = 4'd2;
  localparam logic [3:0] ST_SB   = 4'd3;
  localparam logic [3:0] ST_SC   = 4'd4;
  localparam logic [3:0] ST_SD   = 4'd5;
  localparam logic [3:0] ST_G1   = 4'd6;
  localparam logic [3:0] ST_G2   = 4'd7;
  localparam logic [3:0] ST_G3   = 4'd8;

  localparam logic [8:0] KEY_LIMIT = 9'(MAX_KEY_BYTES);

  logic [7:0] perm_mem [256];
  logic [7:0] key_mem  [256];
  logic [7:0] perm_rd_r;
  logic [7:0] key_rd_r;

  logic       perm_we;
  logic [7:0] perm_waddr;
  logic [7:0] perm_wdata;
  logic       perm_re;
  logic [7:0] perm_raddr;
  logic       key_we;
  logic       key_re;

  logic [3:0] state_r, state_nxt;
  logic [7:0] i_r, i_nxt;
  logic [7:0] j_r, j_nxt;
  logic [7:0] k_r, k_nxt;
  logic [7:0] kidx_r, kidx_nxt;
  logic [8:0] key_count_r, key_count_nxt;
  logic       key_ready_r, key_ready_nxt;
  logic       out_valid_r, out_valid_nxt;

  logic [8:0] n_r, n_nxt;
  logic       key_zero_r, key_zero_nxt;
  logic [7:0] si_r, si_nxt;
  logic [7:0] sj_r, sj_nxt;
  logic [7:0] t_r, t_nxt;
  logic [7:0] value_r, value_nxt;
  out_item_t  out_item_r, out_item_nxt;

  logic       slot_free;
  logic       in_fire;
  logic       key_room;
  logic [8:0] cnt_inc;
  logic [7:0] kb;
  logic [7:0] sb_j;
  logic [7:0] g1_j;
  logic [7:0] g2_t;
  logic [7:0] ks;
  logic       kidx_wrap;
  logic       out_load;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !slot_free;
  assign in_fire   = in_valid && !in_stall;
  assign key_room  = key_count_r < KEY_LIMIT;
  assign cnt_inc   = key_count_r + {8'd0, key_room};
  assign kb        = key_zero_r ? 8'd0 : key_rd_r;
  assign sb_j      = j_r + perm_rd_r + kb;
  assign g1_j      = j_r + perm_rd_r;
  assign g2_t      = si_r + perm_rd_r;
  assign ks        = (t_r == j_r) ? si_r : ((t_r == i_r) ? sj_r : perm_rd_r);
  assign kidx_wrap = ({1'b0, kidx_r} == (n_r - 9'd1));

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    kidx_nxt      = kidx_r;
    key_count_nxt = key_count_r;
    key_ready_nxt = key_ready_r;
    n_nxt         = n_r;
    key_zero_nxt  = key_zero_r;
    si_nxt        = si_r;
    sj_nxt        = sj_r;
    t_nxt         = t_r;
    value_nxt     = value_r;
    out_load      = 1'b0;
    out_item_nxt  = out_item_r;
    perm_we       = 1'b0;
    perm_waddr    = k_r;
    perm_wdata    = k_r;
    perm_re       = 1'b0;
    perm_raddr    = k_r;
    key_we        = 1'b0;
    key_re        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_item.command == CMD_KEY) begin
            key_we        = key_room;
            key_count_nxt = cnt_inc;
            if (in_item.key_last) begin
              key_zero_nxt  = (cnt_inc == 9'd0);
              n_nxt         = (cnt_inc == 9'd0) ? 9'd1 : cnt_inc;
              key_count_nxt = 9'd0;
              k_nxt         = 8'd0;
              state_nxt     = ST_INIT;
            end
          end else if (key_ready_r) begin
            i_nxt      = i_r + 8'd1;
            perm_re    = 1'b1;
            perm_raddr = i_r + 8'd1;
            value_nxt  = in_item.value;
            state_nxt  = ST_G1;
          end else begin
            out_load              = 1'b1;
            out_item_nxt.data_out = in_item.value;
            out_item_nxt.no_key   = 1'b1;
          end
        end
      end
      ST_INIT: begin
        perm_we    = 1'b1;
        perm_waddr = k_r;
        perm_wdata = k_r;
        k_nxt      = k_r + 8'd1;
        if (k_r == 8'hFF) begin
          j_nxt     = 8'd0;
          kidx_nxt  = 8'd0;
          state_nxt = ST_SA;
        end
      end
      ST_SA: begin
        perm_re    = 1'b1;
        perm_raddr = k_r;
        key_re     = 1'b1;
        state_nxt  = ST_SB;
      end
      ST_SB: begin
        j_nxt      = sb_j;
        si_nxt     = perm_rd_r;
        perm_re    = 1'b1;
        perm_raddr = sb_j;
        state_nxt  = ST_SC;
      end
      ST_SC: begin
        perm_we    = 1'b1;
        perm_waddr = k_r;
        perm_wdata = perm_rd_r;
        state_nxt  = ST_SD;
      end
      ST_SD: begin
        perm_we    = 1'b1;
        perm_waddr = j_r;
        perm_wdata = si_r;
        k_nxt      = k_r + 8'd1;
        kidx_nxt   = kidx_wrap ? 8'd0 : kidx_r + 8'd1;
        if (k_r == 8'hFF) begin
          i_nxt         = 8'd0;
          j_nxt         = 8'd0;
          key_ready_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_SA;
        end
      end
      ST_G1: begin
        j_nxt      = g1_j;
        si_nxt     = perm_rd_r;
        perm_re    = 1'b1;
        perm_raddr = g1_j;
        state_nxt  = ST_G2;
      end
      ST_G2: begin
        perm_we    = 1'b1;
        perm_waddr = i_r;
        perm_wdata = perm_rd_r;
        sj_nxt     = perm_rd_r;
        t_nxt      = g2_t;
        perm_re    = 1'b1;
        perm_raddr = g2_t;
        state_nxt  = ST_G3;
      end
      ST_G3: begin
        if (slot_free) begin
          perm_we               = 1'b1;
          perm_waddr            = j_r;
          perm_wdata            = si_r;
          out_load              = 1'b1;
          out_item_nxt.data_out = value_r ^ ks;
          out_item_nxt.no_key   = 1'b0;
          state_nxt             = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);
  end

  // permutation memory
  always_ff @(posedge clk) begin
    if (perm_we) begin
      perm_mem[perm_waddr] <= perm_wdata;
    end
    if (perm_re) begin
      perm_rd_r <= perm_mem[perm_raddr];
    end
  end

  // key memory
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_count_r[7:0]] <= in_item.value;
    end
    if (key_re) begin
      key_rd_r <= key_mem[kidx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      i_r         <= 8'd0;
      j_r         <= 8'd0;
      k_r         <= 8'd0;
      kidx_r      <= 8'd0;
      key_count_r <= 9'd0;
      key_ready_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      kidx_r      <= kidx_nxt;
      key_count_r <= key_count_nxt;
      key_ready_r <= key_ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    key_zero_r <= key_zero_nxt;
    si_r       <= si_nxt;
    sj_r       <= sj_nxt;
    t_r        <= t_nxt;
    value_r    <= value_nxt;
    out_item_r <= out_item_nxt;
  end

`ifndef SYNTHESIS
  a_data_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_item.command == CMD_DATA) && key_ready_r
      |=> (state_r == ST_G1) ##1 (state_r == ST_G2))
    else $error("keyed data byte did not enter the generator sequence");

  a_key_ready_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(key_ready_r))
    else $error("key ready flag dropped");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    perm_we |-> (state_r != ST_IDLE))
    else $error("permutation write while idle");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SA || state_r == ST_SB || state_r == ST_SC || state_r == ST_SD)
      |-> (n_r != 9'd0) && (n_r <= KEY_LIMIT))
    else $error("key length out of range during schedule");
`endif

endmodule

`default_nettype wire
